### rtl/core/slip_crc32_frame_sender_defines.svh
// Assertion macros shared by the SLIP CRC-32 frame sender RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SLIP_CRC32_FRAME_SENDER_DEFINES_SVH
`define SLIP_CRC32_FRAME_SENDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SCFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scfs assertion failed");

// Next-cycle implication, checked out of reset.
`define SCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scfs assertion failed");

`endif

### rtl/core/scfs_pkg.sv
// Package for the SLIP CRC-32 frame sender: constants, job type, sequencer states.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package scfs_pkg;

  localparam logic [7:0]  SLIP_END     = 8'hC0;
  localparam logic [7:0]  SLIP_ESC     = 8'hDB;
  localparam logic [7:0]  SLIP_ESC_END = 8'hDC;
  localparam logic [7:0]  SLIP_ESC_ESC = 8'hDD;
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES     = 32'hFFFFFFFF;

  localparam int CRC_BYTES   = 4;
  localparam int CRC_IDX_W   = $clog2(CRC_BYTES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified input word, as the back end needs it.
  typedef struct packed {
    logic        open_end;
    logic        has_data;
    logic [7:0]  data;
    logic        has_trailer;
    logic [31:0] crc;
  } scfs_job_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_OPEN,
    PH_DATA,
    PH_CRC,
    PH_CLOSE
  } scfs_phase_e;

  // Reflected CRC-32 update over one byte, bit at a time.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/scfs_front.sv
// Front end of the SLIP CRC-32 frame sender: accepts input words, keeps frame
// state and the running CRC, and emits one job per word. Depends on scfs_pkg.
`default_nettype none

module scfs_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               last_byte_i,
  input  wire logic               empty_frame_i,
  input  wire logic               q_ready_i,
  output logic                    push_o,
  output scfs_pkg::scfs_job_t     job_o
);
  import scfs_pkg::*;

  logic        frame_open_q, frame_open_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_base, crc_next;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  // A new frame restarts from all ones.
  assign crc_base = frame_open_q ? crc_q : CRC_ONES;
  assign crc_next = crc32_byte(crc_base, data_byte_i);

  always_comb begin
    frame_open_d = frame_open_q;
    crc_d        = crc_q;
    job_o        = '0;
    if (empty_frame_i) begin
      job_o.open_end    = 1'b1;
      job_o.has_trailer = 1'b1;
      job_o.crc         = '0;
      frame_open_d      = 1'b0;
      crc_d             = CRC_ONES;
    end else begin
      job_o.open_end = !frame_open_q;
      job_o.has_data = 1'b1;
      job_o.data     = data_byte_i;
      if (last_byte_i) begin
        job_o.has_trailer = 1'b1;
        job_o.crc         = ~crc_next;
        frame_open_d      = 1'b0;
        crc_d             = CRC_ONES;
      end else begin
        frame_open_d = 1'b1;
        crc_d        = crc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      crc_q        <= CRC_ONES;
    end else if (push_o) begin
      frame_open_q <= frame_open_d;
      crc_q        <= crc_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/scfs_queue.sv
// Short job queue between front and back end of the SLIP CRC-32 frame sender.
// Depends on scfs_pkg and the shared assertion macros.
`default_nettype none
`include "slip_crc32_frame_sender_defines.svh"

module scfs_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire scfs_pkg::scfs_job_t job_i,
  output logic                    ready_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output scfs_pkg::scfs_job_t     job_o
);
  import scfs_pkg::*;

  scfs_job_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0]   cnt_q;

  assign ready_o = (cnt_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `SCFS_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
  `SCFS_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop_i, cnt_q != '0)
  `SCFS_ASSERT_NEXT(a_push_only_alone_grows, clk_i, rst_ni, push_i && !pop_i, cnt_q != '0)

endmodule

`default_nettype wire

### rtl/core/scfs_back.sv
// Back end of the SLIP CRC-32 frame sender: walks each job through whichever of END,
// escaped data, escaped CRC and closing END it needs into an output register. Depends on scfs_pkg.
`default_nettype none
`include "slip_crc32_frame_sender_defines.svh"

module scfs_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               job_valid_i,
  input  wire scfs_pkg::scfs_job_t job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              line_byte_o,
  output logic                    run_last_o
);
  import scfs_pkg::*;

  scfs_phase_e            phase_q, phase_d, eff_phase;
  logic [CRC_IDX_W-1:0]   idx_q, idx_d;
  logic                   esc_q, esc_d;
  logic                   out_valid_q;
  logic [7:0]             line_q;
  logic                   last_q;

  logic                   load;
  logic [7:0]             sel_byte, crc_byte, emit_byte;
  logic                   byte_done, esc_start, job_done;

  assign load     = job_valid_i && (!out_valid_q || out_ready_i);
  assign crc_byte = 8'(job_i.crc >> {idx_q, 3'b000});

  always_comb begin
    eff_phase = phase_q;
    if (phase_q == PH_START) begin
      eff_phase = job_i.open_end ? PH_OPEN : (job_i.has_data ? PH_DATA : PH_CRC);
    end
  end

  assign sel_byte = (eff_phase == PH_DATA) ? job_i.data : crc_byte;

  // Output decode: byte to send and whether the current source byte is finished.
  always_comb begin
    emit_byte = SLIP_END;
    byte_done = 1'b1;
    esc_start = 1'b0;
    unique case (eff_phase)
      PH_DATA, PH_CRC: begin
        if (esc_q) begin
          emit_byte = (sel_byte == SLIP_END) ? SLIP_ESC_END : SLIP_ESC_ESC;
        end else if (sel_byte == SLIP_END || sel_byte == SLIP_ESC) begin
          emit_byte = SLIP_ESC;
          byte_done = 1'b0;
          esc_start = 1'b1;
        end else begin
          emit_byte = sel_byte;
        end
      end
      default: begin
        emit_byte = SLIP_END;
      end
    endcase
    job_done = byte_done &&
               ((eff_phase == PH_CLOSE) || (eff_phase == PH_DATA && !job_i.has_trailer));
  end

  // Next state of the sequencer.
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    esc_d   = esc_q;
    if (load) begin
      esc_d = esc_start;
      unique case (eff_phase)
        PH_OPEN: begin
          phase_d = job_i.has_data ? PH_DATA : PH_CRC;
          idx_d   = '0;
        end
        PH_DATA: begin
          if (!byte_done) begin
            phase_d = PH_DATA;
          end else begin
            phase_d = job_i.has_trailer ? PH_CRC : PH_START;
          end
          idx_d = '0;
        end
        PH_CRC: begin
          phase_d = PH_CRC;
          if (byte_done) begin
            if (idx_q == CRC_IDX_W'(CRC_BYTES - 1)) begin
              phase_d = PH_CLOSE;
              idx_d   = '0;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
        end
        default: begin
          phase_d = PH_START;
          idx_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      idx_q       <= '0;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      esc_q   <= esc_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      line_q <= emit_byte;
      last_q <= job_done;
    end
  end

  assign pop_o       = load && job_done;
  assign out_valid_o = out_valid_q;
  assign line_byte_o = line_q;
  assign run_last_o  = last_q;

  `SCFS_ASSERT_IMPL(a_esc_phase, clk_i, rst_ni, esc_q, phase_q == PH_DATA || phase_q == PH_CRC)
  `SCFS_ASSERT_IMPL(a_idx_phase, clk_i, rst_ni, idx_q != '0, phase_q == PH_CRC)
  `SCFS_ASSERT_NEXT(a_pop_restarts, clk_i, rst_ni, pop_o, phase_q == PH_START && !esc_q)

endmodule

`default_nettype wire

### rtl/core/slip_crc32_frame_sender.sv
// SLIP CRC-32 frame sender top level: front end, job queue and back end.
// Path: when the back end is idle, a word's first line byte passes through the job
// queue and then the output register; otherwise it waits behind the bytes of earlier words.
// Throughput: one line byte per cycle unless out_ready_i holds off the output; a word
// causes 1 to 12 line bytes. The back end sequencer sets this rate.
// Reset (rst_ni low, asynchronous): no frame open, CRC all ones, queue and output empty.
`default_nettype none

module slip_crc32_frame_sender (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       empty_frame_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      line_byte_o,
  output logic            run_last_o
);
  import scfs_pkg::*;

  // The front end classifies each input word into a job: whether an opening END
  // is needed, the payload byte if any, and the final CRC if the frame closes.
  // The CRC state lives entirely in the front end, so the back end never waits
  // on it and the front end can run ahead by the queue depth.
  logic      push, q_ready, q_valid, pop;
  scfs_job_t push_job, head_job;

  scfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .empty_frame_i (empty_frame_i),
    .q_ready_i     (q_ready),
    .push_o        (push),
    .job_o         (push_job)
  );

  // The queue lets a new word enter while the back end is still expanding an
  // earlier one into line bytes.
  scfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  // The back end pops a job only after its final line byte is loaded into the
  // output register; run_last marks that byte.
  scfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .line_byte_o (line_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

`default_nettype wire

### tb/slip_line_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the SLIP CRC-32 frame sender: predicts the escaped line stream.
// Depends on scfs_pkg for the SLIP codes and the CRC constants.

package slip_line_scoreboard_pkg;
  import scfs_pkg::*;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
  } line_beat_t;

  class slip_line_scoreboard;
    bit          frame_open;
    logic [31:0] crc_acc;
    line_beat_t  line_due[$];
    int          fails;

    function new();
      frame_open = 1'b0;
      crc_acc    = CRC_ONES;
      fails      = 0;
    endfunction

    // Reflected CRC-32, one payload byte, LSB first.
    function logic [31:0] crc_after(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
    endfunction

    function void push_line(logic [7:0] b);
      line_due.push_back('{b, 1'b0});
    endfunction

    function void push_escaped(logic [7:0] b);
      if (b == SLIP_END) begin
        push_line(SLIP_ESC);
        push_line(SLIP_ESC_END);
      end else if (b == SLIP_ESC) begin
        push_line(SLIP_ESC);
        push_line(SLIP_ESC_ESC);
      end else begin
        push_line(b);
      end
    endfunction

    function void push_trailer(logic [31:0] crc);
      for (int i = 0; i < 4; i++) begin
        push_escaped(crc[8*i +: 8]);
      end
      push_line(SLIP_END);
    endfunction

    // Called once per accepted input word.
    function void note_word(logic [7:0] data, logic last, logic empty);
      if (empty) begin
        frame_open = 1'b0;
        crc_acc    = CRC_ONES;
        push_line(SLIP_END);
        push_trailer(crc_acc ^ CRC_ONES);
      end else begin
        if (!frame_open) begin
          push_line(SLIP_END);
          frame_open = 1'b1;
          crc_acc    = CRC_ONES;
        end
        push_escaped(data);
        crc_acc = crc_after(crc_acc, data);
        if (last) begin
          push_trailer(crc_acc ^ CRC_ONES);
          frame_open = 1'b0;
          crc_acc    = CRC_ONES;
        end
      end
      line_due[line_due.size() - 1].run_last = 1'b1;
    endfunction

    function void check_line(logic [7:0] line_byte, logic run_last);
      line_beat_t due;
      if (line_due.size() == 0) begin
        $error("line_byte %h arrived with nothing expected", line_byte);
        fails++;
        return;
      end
      due = line_due.pop_front();
      if (line_byte !== due.line_byte) begin
        $error("line_byte: expected %h, actual %h", due.line_byte, line_byte);
        fails++;
      end
      if (run_last !== due.run_last) begin
        $error("run_last: expected %b, actual %b", due.run_last, run_last);
        fails++;
      end
    endfunction

    function int pending();
      return line_due.size();
    endfunction
  endclass

endpackage

### tb/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for slip_crc32_frame_sender: drives words, checks line bytes.
// Depends on scfs_pkg and slip_line_scoreboard_pkg.

module tb;
  import scfs_pkg::*;
  import slip_line_scoreboard_pkg::*;

  // Roughly how many random words follow the directed part.
  localparam int RANDOM_WORDS    = 440;
  // The receiver holds off once this many words have gone in.
  localparam int HOLD_OFF_AT     = 150;
  localparam int HOLD_OFF_CYCLES = 300;
  // The sender drains the block once this many words have gone in.
  localparam int PAUSE_AT        = 320;
  // Cycles allowed after the last expected byte for stray output to show up.
  localparam int DRAIN_CYCLES    = 16;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic [7:0] data_byte_i   = 8'h00;
  logic       last_byte_i   = 1'b0;
  logic       empty_frame_i = 1'b0;
  logic       out_ready_i   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] line_byte_o;
  logic       run_last_o;

  // Words accepted so far; the receiver watches it to place its long hold-off.
  int words_sent = 0;
  // Words left in the current sender burst before the next gap.
  int burst_left = 0;

  slip_line_scoreboard sb = new();

  slip_crc32_frame_sender u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .empty_frame_i(empty_frame_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_byte_o  (line_byte_o),
    .run_last_o   (run_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Offers one word and returns at the edge that accepts it. It is always called
  // at a rising edge. When the current burst runs out it drops valid and idles for
  // a random nonzero gap before returning, so valid never gets two assignments in one
  // step: either it stays high into the next word or it was lowered cycles ago.
  task automatic send_word(input logic [7:0] data, input logic last, input logic empty);
    int gap;
    in_valid_i    <= 1'b1;
    data_byte_i   <= data;
    last_byte_i   <= last;
    empty_frame_i <= empty;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(data, last, empty);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Payload bytes lean heavily on the two SLIP codes that need escaping and on the
  // two escape suffixes, which must pass through untouched.
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 15))
      0, 1:    return SLIP_END;
      2, 3:    return SLIP_ESC;
      4:       return SLIP_ESC_END;
      5:       return SLIP_ESC_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sender: reset, a directed sweep, then random frames.
  initial begin : sender
    int  len;
    int  kind;
    int  first_random;
    bit  paused;
    bit  broken;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // An empty frame with no frame open; last_byte and data_byte must be ignored.
    send_word(8'h5A, 1'b1, 1'b1);
    send_word(SLIP_END, 1'b0, 1'b1);
    // Single-byte frames at the extremes of the byte range.
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    // A frame that opens on END and carries every code that escaping touches.
    send_word(SLIP_END, 1'b0, 1'b0);
    send_word(SLIP_ESC, 1'b0, 1'b0);
    send_word(SLIP_ESC_END, 1'b0, 1'b0);
    send_word(SLIP_ESC_ESC, 1'b0, 1'b0);
    send_word(SLIP_END, 1'b1, 1'b0);
    // A single escaped byte that is also the last one.
    send_word(SLIP_ESC, 1'b1, 1'b0);
    // An open frame abandoned by an empty frame, twice, the second with last_byte set.
    send_word(8'h12, 1'b0, 1'b0);
    send_word(8'h34, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hAB, 1'b0, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1);
    // Ordinary frames, multi-byte and single-byte, with alternating bit patterns.
    send_word(8'h55, 1'b0, 1'b0);
    send_word(8'hAA, 1'b0, 1'b0);
    send_word(8'h7F, 1'b0, 1'b0);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'hFE, 1'b0, 1'b0);
    send_word(SLIP_ESC, 1'b1, 1'b0);

    // Random part: mostly complete frames, some bare empty frames, and some
    // partial frames that an empty frame cuts off.
    first_random = words_sent;
    while (words_sent < first_random + RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        broken = (kind < 16);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_word(pick_payload(), !broken && (i == len - 1), 1'b0);
        end
        if (broken) begin
          send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
      end

      // Once in the run, stop offering and let the block drain completely.
      if (!paused && words_sent >= PAUSE_AT) begin
        paused = 1'b1;
        if (in_valid_i) in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
    end

    if (in_valid_i) in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.pending() != 0) begin
      $error("%0d line bytes still expected at the end", sb.pending());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: cycles through four stall patterns in turn, and once holds
  // off for a long stretch while the sender keeps offering, so the job queue
  // fills and in_ready_o drops.
  initial begin : receiver
    int cycle;
    bit held;
    cycle = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk_i);
      cycle++;
      if (!held && words_sent >= HOLD_OFF_AT) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        case ((cycle / 64) % 4)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ((cycle % 7) >= 3);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Output monitor. Values read right after the edge are the ones the edge saw.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_line(line_byte_o, run_last_o);
    end
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
